// ----- hdl/npcs_pkg.sv -----
// Package for the nearest palette color search: constants, item types and helpers.
package npcs_pkg;

  localparam int ENTRIES_DEFAULT = 256;

  localparam int COMP_W  = 8;
  localparam int INDEX_W = 8;
  localparam int PIXEL_W = 8;
  localparam int DIST_W  = 10;
  localparam int COUNT_W = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [DIST_W-1:0]  THRESHOLD_RESET = 10'd384;
  localparam logic [COUNT_W-1:0] COUNT_RESET     = 9'd256;

  // Input item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 1'b1;

  // Palette write broadcast to every cell
  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] index;
    logic [COMP_W-1:0]  red;
    logic [COMP_W-1:0]  green;
    logic [COMP_W-1:0]  blue;
    logic [PIXEL_W-1:0] pixel;
  } npcs_wr_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               done;      // exact match taken, later cells pass through
    logic               hit;
    logic [COMP_W-1:0]  red;
    logic [COMP_W-1:0]  green;
    logic [COMP_W-1:0]  blue;
    logic [DIST_W-1:0]  best;      // starts at threshold
    logic [PIXEL_W-1:0] best_pix;
    logic [COUNT_W-1:0] count;
  } npcs_token_t;

  function automatic logic [COMP_W-1:0] absdiff(input logic [COMP_W-1:0] a,
                                                input logic [COMP_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- hdl/npcs_ifs.sv -----
// Channel interfaces: request items, result items and configuration writes.
interface npcs_req_if import npcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [INDEX_W-1:0] index;
  logic [COMP_W-1:0]  red;
  logic [COMP_W-1:0]  green;
  logic [COMP_W-1:0]  blue;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, mode, index, red, green, blue, pixel, input ready);
  modport sink   (input valid, mode, index, red, green, blue, pixel, output ready);
endinterface

interface npcs_res_if import npcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic               exact;
  logic [PIXEL_W-1:0] match_pixel;
  logic [DIST_W-1:0]  distance;

  modport source (output valid, found, exact, match_pixel, distance, input ready);
  modport sink   (input valid, found, exact, match_pixel, distance, output ready);
endinterface

interface npcs_cfg_if import npcs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/npcs_cell.sv -----
// One palette cell: holds an entry and folds it into the passing search token.
module npcs_cell import npcs_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  npcs_wr_t    wr,
  input  npcs_token_t tok_in,
  output npcs_token_t tok_out
);

  logic [COMP_W-1:0]  red;
  logic [COMP_W-1:0]  green;
  logic [COMP_W-1:0]  blue;
  logic [PIXEL_W-1:0] pixel;

  npcs_token_t        tok;
  npcs_token_t        tok_next;
  logic [DIST_W-1:0]  gap;
  logic               active;

  always_ff @(posedge clk) begin
    if (wr.en && (int'(wr.index) == CELL_IDX)) begin
      red   <= wr.red;
      green <= wr.green;
      blue  <= wr.blue;
      pixel <= wr.pixel;
    end
  end

  assign gap = DIST_W'(absdiff(red, tok_in.red))
             + DIST_W'(absdiff(green, tok_in.green))
             + DIST_W'(absdiff(blue, tok_in.blue));

  assign active = tok_in.valid && !tok_in.done && (int'(tok_in.count) > CELL_IDX);

  always_comb begin
    tok_next = tok_in;
    if (active) begin
      if (gap == '0) begin
        tok_next.done     = 1'b1;
        tok_next.hit      = 1'b1;
        tok_next.best     = '0;
        tok_next.best_pix = pixel;
      end else if (gap < tok_in.best) begin
        tok_next.hit      = 1'b1;
        tok_next.best     = gap;
        tok_next.best_pix = pixel;
      end
    end
  end

  // Only the valid bit needs a reset; payload just follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (adv) begin
      tok <= tok_next;
    end
  end

  assign tok_out = tok;

endmodule

// ----- hdl/nearest_palette_color_search.sv -----
// Top level: palette cell chain, request/config handling and result register.
// A query item's token is taken into cell 0 at the accept edge, then moves through each further
// cell register in turn and then into the result register; the whole chain holds while a finished
// token waits on a full result register. One query is in the chain at a time: no new request
// is taken until it leaves; loads are taken every cycle while no query is in the chain.
// Reset (rst, synchronous): threshold 384, entries_in_use 256, chain and result empty;
// palette entries keep no reset value and must be loaded before they are searched.
module nearest_palette_color_search import npcs_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  npcs_req_if.sink  request,
  npcs_res_if.source result,
  npcs_cfg_if.sink  cfg
);

  logic [DIST_W-1:0]  threshold;
  logic [COUNT_W-1:0] entries_in_use;

  logic               busy;       // a query token is in the chain
  logic               adv;        // chain advances
  logic               req_accept;
  npcs_wr_t           wr;
  npcs_token_t        head;
  npcs_token_t        chain [ENTRIES+1];
  logic [ENTRIES-1:0] vbits;
  npcs_token_t        last;

  logic               res_valid;
  logic               res_found;
  logic               res_exact;
  logic [PIXEL_W-1:0] res_pixel;
  logic [DIST_W-1:0]  res_dist;

  // Config writes are always taken; the block is idle by contract when they come.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= THRESHOLD_RESET;
      entries_in_use <= COUNT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_THRESHOLD:      threshold      <= cfg.data;
        REG_ENTRIES_IN_USE: entries_in_use <= cfg.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // One query at a time; loads wait while a token walks the chain.
  assign request.ready = !busy;
  assign req_accept    = request.valid && request.ready;

  // Load: broadcast to all cells, the cell with the matching index keeps it.
  // An index with no cell behind it is dropped.
  always_comb begin
    wr.en    = req_accept && (request.mode == MODE_LOAD);
    wr.index = request.index;
    wr.red   = request.red;
    wr.green = request.green;
    wr.blue  = request.blue;
    wr.pixel = request.pixel;
  end

  // Query token enters cell 0 with the threshold as the best distance so far.
  always_comb begin
    head.valid    = req_accept && (request.mode == MODE_QUERY);
    head.done     = 1'b0;
    head.hit      = 1'b0;
    head.red      = request.red;
    head.green    = request.green;
    head.blue     = request.blue;
    head.best     = threshold;
    head.best_pix = '0;
    head.count    = entries_in_use;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    npcs_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .wr      (wr),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
    assign vbits[i] = chain[i+1].valid;
  end

  assign last = chain[ENTRIES];

  // Whole chain holds when the finished token cannot move into a full result register.
  assign adv = !(last.valid && res_valid && !result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (head.valid) begin
      busy <= 1'b1;
    end else if (last.valid && adv) begin
      busy <= 1'b0;
    end
  end

  // Result register; not found reports zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (last.valid && adv) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last.valid && adv) begin
      res_found <= last.hit;
      res_exact <= last.done;
      res_pixel <= last.hit ? last.best_pix : '0;
      res_dist  <= last.hit ? last.best : '0;
    end
  end

  assign result.valid       = res_valid;
  assign result.found       = res_found;
  assign result.exact       = res_exact;
  assign result.match_pixel = res_pixel;
  assign result.distance    = res_dist;

  // At most one token in the chain at any time.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(vbits) <= 1)
    else $error("more than one search token in the chain");

  // A token in the chain means the block is marked busy.
  a_token_busy: assert property (@(posedge clk) disable iff (rst)
    (vbits != '0) |-> busy)
    else $error("token in chain while not busy");

  // An exact result is a found result at distance zero.
  a_exact_found: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_exact) |-> (res_found && (res_dist == '0)))
    else $error("exact result without found or with nonzero distance");

  // A not-found result carries zero pixel and distance.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_found) |-> (!res_exact && (res_pixel == '0) && (res_dist == '0)))
    else $error("not-found result with nonzero fields");

  // A query entering clears the busy-free state on the next edge.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    head.valid |=> busy)
    else $error("query accepted but block not busy");

endmodule
